@@ sv/tsb_pkg.sv @@
// shared types, constants and helpers of the bilinear texture sampler
`default_nettype none
package tsb_pkg;

  localparam int COORD_FRAC_BITS = 16;
  localparam int COORD_W         = COORD_FRAC_BITS + 1;
  localparam int PROD_W          = COORD_W + 8;
  localparam int MUL_W           = PROD_W + COORD_W;
  localparam int SUM_W           = MUL_W + 1;
  localparam int OUT_SHIFT       = 2 * COORD_FRAC_BITS - 8;
  localparam int TEXEL_W         = 24;
  localparam int SIZE_W          = 9;
  localparam int FIFO_DEPTH      = 8;
  localparam int PTR_W           = $clog2(FIFO_DEPTH);
  localparam int CNT_W           = $clog2(FIFO_DEPTH + 1);

  localparam logic [COORD_W-1:0] COORD_ONE  = {1'b1, {COORD_FRAC_BITS{1'b0}}};
  localparam logic [COORD_W-1:0] COORD_HALF = COORD_ONE >> 1;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_FETCH = 1'b1;

  localparam logic FILTER_NEAREST  = 1'b0;
  localparam logic FILTER_BILINEAR = 1'b1;

  typedef enum logic [1:0] {
    REG_TEX_WIDTH   = 2'd0,
    REG_TEX_HEIGHT  = 2'd1,
    REG_FILTER_MODE = 2'd2
  } tsb_reg_t;

  // neighbor order of the four bilinear reads
  typedef enum logic [1:0] {
    STEP_00 = 2'd0,
    STEP_10 = 2'd1,
    STEP_01 = 2'd2,
    STEP_11 = 2'd3
  } tsb_step_t;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } tsb_rgb16_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] r;
    r = s;
    if (s == '0) r = SIZE_W'(1);
    else if (s > SIZE_W'(256)) r = SIZE_W'(256);
    return r;
  endfunction

endpackage
`default_nettype wire

@@ sv/tsb_req_if.sv @@
// request channel of the texture sampler: texel writes and sample fetches
`default_nettype none
interface tsb_req_if import tsb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               func;
  logic [15:0]        texel_addr;
  logic [7:0]         red_in;
  logic [7:0]         green_in;
  logic [7:0]         blue_in;
  logic [COORD_W-1:0] u_coord;
  logic [COORD_W-1:0] v_coord;

  modport source (
    output valid, func, texel_addr, red_in, green_in, blue_in, u_coord, v_coord,
    input  ready
  );

  modport sink (
    input  valid, func, texel_addr, red_in, green_in, blue_in, u_coord, v_coord,
    output ready
  );
endinterface
`default_nettype wire

@@ sv/tsb_rsp_if.sv @@
// response channel of the texture sampler: one sampled color per fetch
`default_nettype none
interface tsb_rsp_if import tsb_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [15:0] red_out;
  logic [15:0] green_out;
  logic [15:0] blue_out;

  modport source (
    output valid, red_out, green_out, blue_out,
    input  ready
  );

  modport sink (
    input  valid, red_out, green_out, blue_out,
    output ready
  );
endinterface
`default_nettype wire

@@ sv/tsb_ram.sv @@
// generic simple dual-port ram with registered read
`default_nettype none
module tsb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic                                  re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ sv/texture_sampler_bilinear.sv @@
// texture sampler top level: texel store, coordinate pipeline and bilinear blend
//
// req carries one transaction per item: func 0 writes the rgb texel at
// texel_addr, func 1 fetches a sample at (u_coord, v_coord) in Q1.16, u mirrored.
// rsp returns one Q8.8 color per fetch, in request order; writes return nothing.
// cfg_wr_en/cfg_index/cfg_wdata set width, height and filter mode while idle.
// the texel store is one ram with a single read port, so a bilinear fetch
// holds the issue stage for one read per neighbour; writes and nearest
// fetches need a single ram access, and the next request enters the issue
// stage once the last access of the one before is issued. a fetch passes
// stage a, stage b, issue, read return, finish and blend stages, then the queue.
// responses collect in an 8-entry queue; fetches are issued only while the
// queue has a free slot counted for them, so a stalled receiver backs up
// into req.ready without losing or reordering anything.
// rst clears all control state and sets width 1, height 1, nearest mode;
// the texel store is not cleared and holds nothing useful until written.
`default_nettype none
module texture_sampler_bilinear import tsb_pkg::*; #(
  parameter int MAX_TEXELS = 65536
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_wr_en,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [SIZE_W-1:0] cfg_wdata,
  tsb_req_if.sink                req,
  tsb_rsp_if.source              rsp
);

  localparam int AW = (MAX_TEXELS > 1) ? $clog2(MAX_TEXELS) : 1;

  // configuration
  logic [SIZE_W-1:0] tex_width;
  logic [SIZE_W-1:0] tex_height;
  logic              filter_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      tex_width   <= SIZE_W'(1);
      tex_height  <= SIZE_W'(1);
      filter_mode <= FILTER_NEAREST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_TEX_WIDTH:   tex_width   <= cfg_wdata;
        REG_TEX_HEIGHT:  tex_height  <= cfg_wdata;
        REG_FILTER_MODE: filter_mode <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  logic [SIZE_W-1:0] w_eff, h_eff, w_m1, h_m1;
  assign w_eff = clamp_size(tex_width);
  assign h_eff = clamp_size(tex_height);
  assign w_m1  = w_eff - SIZE_W'(1);
  assign h_m1  = h_eff - SIZE_W'(1);

  // stage handshake
  logic a_vld, b_vld, i_vld;
  logic a_free, b_free, iss_free, iss_go, iss_last;
  logic credit_ok;

  assign b_free = !b_vld || iss_free;
  assign a_free = !a_vld || b_free;
  assign req.ready = a_free;

  // stage a: saturate, mirror and scale coordinates
  logic               a_func, a_mode;
  logic [15:0]        a_addr;
  logic [TEXEL_W-1:0] a_rgb;
  logic [PROD_W-1:0]  a_pu, a_pv;
  logic [COORD_W-1:0] u_sat, v_sat, u_mir;

  assign u_sat = (req.u_coord > COORD_ONE) ? COORD_ONE : req.u_coord;
  assign v_sat = (req.v_coord > COORD_ONE) ? COORD_ONE : req.v_coord;
  assign u_mir = COORD_ONE - u_sat;

  always_ff @(posedge clk) begin
    if (rst) a_vld <= 1'b0;
    else if (a_free) a_vld <= req.valid;
  end

  always_ff @(posedge clk) begin
    if (a_free && req.valid) begin
      a_func <= req.func;
      a_mode <= filter_mode;
      a_addr <= req.texel_addr;
      a_rgb  <= {req.red_in, req.green_in, req.blue_in};
      a_pu   <= PROD_W'(u_mir) * PROD_W'(w_m1);
      a_pv   <= PROD_W'(v_sat) * PROD_W'(h_m1);
    end
  end

  // stage b: texel coordinates, clamped neighbours and row bases
  logic                       b_func, b_mode;
  logic [15:0]                b_addr;
  logic [TEXEL_W-1:0]         b_rgb;
  logic [7:0]                 b_x, b_x1;
  logic [15:0]                b_base0, b_base1;
  logic [COORD_FRAC_BITS-1:0] b_fu, b_fv;

  logic [PROD_W-1:0] u_round, v_round;
  logic [SIZE_W-1:0] x_sel, y_sel, x_c, y_c, x_inc, y_inc, x1_c, y1_c;

  always_comb begin
    u_round = a_pu + PROD_W'(COORD_HALF);
    v_round = a_pv + PROD_W'(COORD_HALF);
    if (a_mode == FILTER_BILINEAR) begin
      x_sel = a_pu[COORD_FRAC_BITS+8:COORD_FRAC_BITS];
      y_sel = a_pv[COORD_FRAC_BITS+8:COORD_FRAC_BITS];
    end else begin
      x_sel = u_round[COORD_FRAC_BITS+8:COORD_FRAC_BITS];
      y_sel = v_round[COORD_FRAC_BITS+8:COORD_FRAC_BITS];
    end
    x_c   = (x_sel > w_m1) ? w_m1 : x_sel;
    y_c   = (y_sel > h_m1) ? h_m1 : y_sel;
    x_inc = x_c + SIZE_W'(1);
    y_inc = y_c + SIZE_W'(1);
    x1_c  = (x_inc > w_m1) ? w_m1 : x_inc;
    y1_c  = (y_inc > h_m1) ? h_m1 : y_inc;
  end

  always_ff @(posedge clk) begin
    if (rst) b_vld <= 1'b0;
    else if (b_free) b_vld <= a_vld;
  end

  always_ff @(posedge clk) begin
    if (b_free && a_vld) begin
      b_func  <= a_func;
      b_mode  <= a_mode;
      b_addr  <= a_addr;
      b_rgb   <= a_rgb;
      b_x     <= x_c[7:0];
      b_x1    <= x1_c[7:0];
      b_base0 <= 16'(18'(y_c) * 18'(w_eff));
      b_base1 <= 16'(18'(y1_c) * 18'(w_eff));
      b_fu    <= a_pu[COORD_FRAC_BITS-1:0];
      b_fv    <= a_pv[COORD_FRAC_BITS-1:0];
    end
  end

  // issue stage: one ram access per cycle while no fetch waits for a queue slot, in request order
  logic                       i_func, i_mode;
  logic [15:0]                i_addr;
  logic [TEXEL_W-1:0]         i_rgb;
  logic [7:0]                 i_x, i_x1;
  logic [15:0]                i_base0, i_base1;
  logic [COORD_FRAC_BITS-1:0] i_fu, i_fv;
  tsb_step_t                  i_step;

  logic [15:0]        rd_base, rd_idx;
  logic [7:0]         rd_xo;
  logic [COORD_W-1:0] rd_wt, rd_gv;
  logic               rd_in_range, wr_in_range, fetch_start;

  assign iss_go   = i_vld && (i_func == FUNC_WRITE || i_step != STEP_00 || credit_ok);
  assign iss_last = (i_func == FUNC_WRITE) || (i_mode == FILTER_NEAREST) ||
                    (i_step == STEP_11);
  assign iss_free = !i_vld || (iss_go && iss_last);
  assign fetch_start = iss_go && (i_func == FUNC_FETCH) && (i_step == STEP_00);

  always_comb begin
    rd_base = (i_step == STEP_01 || i_step == STEP_11) ? i_base1 : i_base0;
    rd_xo   = (i_step == STEP_10 || i_step == STEP_11) ? i_x1 : i_x;
    rd_idx  = rd_base + 16'(rd_xo);
    rd_wt   = (i_step == STEP_10 || i_step == STEP_11) ? {1'b0, i_fu}
                                                       : COORD_ONE - {1'b0, i_fu};
    rd_gv   = COORD_ONE - {1'b0, i_fv};
    rd_in_range = {16'd0, rd_idx} < 32'(MAX_TEXELS);
    wr_in_range = {16'd0, i_addr} < 32'(MAX_TEXELS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      i_vld  <= 1'b0;
      i_step <= STEP_00;
    end else begin
      if (iss_free) i_vld <= b_vld;
      if (iss_go) i_step <= iss_last ? STEP_00 : tsb_step_t'(i_step + 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (iss_free && b_vld) begin
      i_func  <= b_func;
      i_mode  <= b_mode;
      i_addr  <= b_addr;
      i_rgb   <= b_rgb;
      i_x     <= b_x;
      i_x1    <= b_x1;
      i_base0 <= b_base0;
      i_base1 <= b_base1;
      i_fu    <= b_fu;
      i_fv    <= b_fv;
    end
  end

  // texel store
  logic               ram_we, ram_re;
  logic [TEXEL_W-1:0] ram_rdata;

  assign ram_we = i_vld && (i_func == FUNC_WRITE) && wr_in_range;
  assign ram_re = iss_go && (i_func == FUNC_FETCH);

  tsb_ram #(
    .WIDTH (TEXEL_W),
    .DEPTH (MAX_TEXELS)
  ) u_texel_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(i_addr)),
    .wdata (i_rgb),
    .re    (ram_re),
    .raddr (AW'(rd_idx)),
    .rdata (ram_rdata)
  );

  // read return stage: weight and accumulate each row
  logic                       r_vld, r_near, r_zero;
  tsb_step_t                  r_step;
  logic [COORD_W-1:0]         r_wt, r_gv, r_fv;

  always_ff @(posedge clk) begin
    if (rst) r_vld <= 1'b0;
    else r_vld <= ram_re;
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      r_near <= (i_mode == FILTER_NEAREST);
      r_step <= i_step;
      r_zero <= !rd_in_range;
      r_wt   <= rd_wt;
      r_gv   <= rd_gv;
      r_fv   <= {1'b0, i_fv};
    end
  end

  logic [TEXEL_W-1:0] texel_q;
  logic [PROD_W-1:0]  r_prod  [3];
  logic [PROD_W-1:0]  top_acc [3];
  logic [PROD_W-1:0]  bot_acc [3];

  assign texel_q = r_zero ? '0 : ram_rdata;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      r_prod[k] = PROD_W'(texel_q[TEXEL_W-1-8*k -: 8]) * PROD_W'(r_wt);
    end
  end

  always_ff @(posedge clk) begin
    if (r_vld && !r_near) begin
      for (int k = 0; k < 3; k++) begin
        case (r_step)
          STEP_00: top_acc[k] <= r_prod[k];
          STEP_10: top_acc[k] <= top_acc[k] + r_prod[k];
          STEP_01: bot_acc[k] <= r_prod[k];
          STEP_11: bot_acc[k] <= bot_acc[k] + r_prod[k];
          default: ;
        endcase
      end
    end
  end

  // finish stage: one sample complete
  logic               f_vld, f_near;
  logic [TEXEL_W-1:0] f_rgb;
  logic [COORD_W-1:0] f_gv, f_fv;

  always_ff @(posedge clk) begin
    if (rst) f_vld <= 1'b0;
    else f_vld <= r_vld && (r_near || r_step == STEP_11);
  end

  always_ff @(posedge clk) begin
    if (r_vld) begin
      f_near <= r_near;
      f_rgb  <= texel_q;
      f_gv   <= r_gv;
      f_fv   <= r_fv;
    end
  end

  // vertical blend products
  logic               m_vld, m_near;
  logic [TEXEL_W-1:0] m_rgb;
  logic [MUL_W-1:0]   m_ptop [3];
  logic [MUL_W-1:0]   m_pbot [3];

  always_ff @(posedge clk) begin
    if (rst) m_vld <= 1'b0;
    else m_vld <= f_vld;
  end

  always_ff @(posedge clk) begin
    if (f_vld) begin
      m_near <= f_near;
      m_rgb  <= f_rgb;
      for (int k = 0; k < 3; k++) begin
        m_ptop[k] <= MUL_W'(top_acc[k]) * MUL_W'(f_gv);
        m_pbot[k] <= MUL_W'(bot_acc[k]) * MUL_W'(f_fv);
      end
    end
  end

  logic [SUM_W-1:0] m_sum [3];
  logic [15:0]      res_ch [3];
  tsb_rgb16_t       res;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      m_sum[k] = SUM_W'(m_ptop[k]) + SUM_W'(m_pbot[k]);
      res_ch[k] = m_near ? {m_rgb[TEXEL_W-1-8*k -: 8], 8'h00}
                         : m_sum[k][OUT_SHIFT+15:OUT_SHIFT];
    end
    res = '{red: res_ch[0], green: res_ch[1], blue: res_ch[2]};
  end

  // response queue and slot credits
  tsb_rgb16_t       fifo_mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] fifo_cnt, outst;
  logic             push, pop;

  assign push      = m_vld;
  assign pop       = rsp.valid && rsp.ready;
  assign credit_ok = outst < CNT_W'(FIFO_DEPTH);

  always_ff @(posedge clk) begin
    if (push) fifo_mem[wr_ptr] <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      fifo_cnt <= '0;
      outst    <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PTR_W'(1);
      if (pop) rd_ptr <= rd_ptr + PTR_W'(1);
      fifo_cnt <= fifo_cnt + CNT_W'(push) - CNT_W'(pop);
      outst    <= outst + CNT_W'(fetch_start) - CNT_W'(pop);
    end
  end

  assign rsp.valid     = fifo_cnt != '0;
  assign rsp.red_out   = fifo_mem[rd_ptr].red;
  assign rsp.green_out = fifo_mem[rd_ptr].green;
  assign rsp.blue_out  = fifo_mem[rd_ptr].blue;

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && fifo_cnt == CNT_W'(FIFO_DEPTH) && !pop))
    else $error("response queue overflow");

  a_credit_cover: assert property (@(posedge clk) disable iff (rst)
    outst >= fifo_cnt)
    else $error("queued responses exceed issued fetches");

  a_single_access: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re))
    else $error("texel store read and written in one cycle");

  a_bilinear_seq: assert property (@(posedge clk) disable iff (rst)
    r_vld && !r_near && r_step == STEP_00 |=> r_vld && r_step == STEP_10)
    else $error("bilinear read sequence broken");

endmodule
`default_nettype wire
